### sv/aes_block_cipher_defines.svh
// Assertion macros shared by the cipher RTL.
`ifndef AES_BLOCK_CIPHER_DEFINES_SVH
`define AES_BLOCK_CIPHER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define AES_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define AES_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/aes_pkg.sv
// Types, tables and GF(2^8) helpers for the AES cipher.
`timescale 1ns / 1ps
package aes_pkg;

   localparam int BLOCK_COLUMNS = 4;
   localparam int KEY_ROWS      = 15;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_KEYWAIT,
      ST_ROUND
   } aes_state_type;

   typedef struct packed {
      logic decrypt;
      logic first;
      logic last;
   } round_ctrl_type;

   localparam logic [2:0] CSR_KEY_SIZE   = 3'd0;
   localparam logic [2:0] CSR_KEY_WORD_0 = 3'd1;
   localparam logic [2:0] CSR_KEY_WORD_1 = 3'd2;
   localparam logic [2:0] CSR_KEY_WORD_2 = 3'd3;
   localparam logic [2:0] CSR_KEY_WORD_3 = 3'd4;

   localparam logic [1:0] KEY_SIZE_128 = 2'd0;
   localparam logic [1:0] KEY_SIZE_192 = 2'd1;

   typedef logic [7:0] sbox_table_type [256];

   localparam sbox_table_type SBOX = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   function automatic sbox_table_type invert_table(sbox_table_type fwd);
      sbox_table_type t;
      for (int i = 0; i < 256; i++) begin
         t[fwd[i]] = 8'(i);
      end
      return t;
   endfunction

   localparam sbox_table_type INV_SBOX = invert_table(SBOX);

   function automatic logic [7:0] xtime(logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   // One column of MixColumns or InvMixColumns, row 0 in the top byte.
   function automatic logic [31:0] mix_col(logic [7:0] a0, logic [7:0] a1,
                                           logic [7:0] a2, logic [7:0] a3,
                                           logic inverse);
      logic [7:0] a [4];
      logic [7:0] x2 [4];
      logic [7:0] x4 [4];
      logic [7:0] x8 [4];
      logic [7:0] m3 [4];
      logic [7:0] m9 [4];
      logic [7:0] mb [4];
      logic [7:0] md [4];
      logic [7:0] me [4];
      logic [31:0] r;
      a[0] = a0;
      a[1] = a1;
      a[2] = a2;
      a[3] = a3;
      for (int k = 0; k < 4; k++) begin
         x2[k] = xtime(a[k]);
         x4[k] = xtime(x2[k]);
         x8[k] = xtime(x4[k]);
         m3[k] = x2[k] ^ a[k];
         m9[k] = x8[k] ^ a[k];
         mb[k] = x8[k] ^ x2[k] ^ a[k];
         md[k] = x8[k] ^ x4[k] ^ a[k];
         me[k] = x8[k] ^ x4[k] ^ x2[k];
      end
      if (inverse) begin
         r = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
              m9[0] ^ me[1] ^ mb[2] ^ md[3],
              md[0] ^ m9[1] ^ me[2] ^ mb[3],
              mb[0] ^ md[1] ^ m9[2] ^ me[3]};
      end else begin
         r = {x2[0] ^ m3[1] ^ a[2] ^ a[3],
              a[0] ^ x2[1] ^ m3[2] ^ a[3],
              a[0] ^ a[1] ^ x2[2] ^ m3[3],
              m3[0] ^ a[1] ^ a[2] ^ x2[3]};
      end
      return r;
   endfunction

endpackage

### sv/aes_round.sv
// One AES round, forward or inverse, shared by every round of a block.
`timescale 1ns / 1ps
module aes_round (
   input  logic                    [127:0] state_in,
   input  logic                    [127:0] round_key,
   input  aes_pkg::round_ctrl_type         ctrl,
   output logic                    [127:0] state_out
);
   import aes_pkg::*;

   logic [7:0] s   [16];
   logic [7:0] kb  [16];
   logic [7:0] sb  [16];
   logic [7:0] sr  [16];
   logic [7:0] isr [16];
   logic [7:0] ark [16];
   logic [7:0] o   [16];
   logic [31:0] col;

   always_comb begin
      col = '0;
      for (int n = 0; n < 16; n++) begin
         s[n]  = state_in[127 - 8 * n -: 8];
         kb[n] = round_key[127 - 8 * n -: 8];
         sb[n] = SBOX[s[n]];
      end
      // byte n sits in row n mod 4, column n / 4
      for (int c = 0; c < BLOCK_COLUMNS; c++) begin
         for (int r = 0; r < 4; r++) begin
            sr[c * 4 + r]  = sb[((c + r) & 3) * 4 + r];
            isr[c * 4 + r] = INV_SBOX[s[((c - r + 4) & 3) * 4 + r]];
         end
      end
      for (int n = 0; n < 16; n++) begin
         ark[n] = ctrl.decrypt ? (isr[n] ^ kb[n]) : sr[n];
      end
      for (int c = 0; c < BLOCK_COLUMNS; c++) begin
         col = mix_col(ark[c * 4], ark[c * 4 + 1], ark[c * 4 + 2], ark[c * 4 + 3],
                       ctrl.decrypt);
         for (int r = 0; r < 4; r++) begin
            if (ctrl.first) begin
               o[c * 4 + r] = s[c * 4 + r] ^ kb[c * 4 + r];
            end else if (ctrl.decrypt) begin
               o[c * 4 + r] = ctrl.last ? ark[c * 4 + r] : col[31 - 8 * r -: 8];
            end else begin
               o[c * 4 + r] = (ctrl.last ? ark[c * 4 + r] : col[31 - 8 * r -: 8])
                              ^ kb[c * 4 + r];
            end
         end
      end
      for (int n = 0; n < 16; n++) begin
         state_out[127 - 8 * n -: 8] = o[n];
      end
   end

endmodule

### sv/aes_block_cipher.sv
// AES-128/192/256 block cipher top level with key expansion and round sequencer.
// Each accepted block first expands the round keys from the key registers, one
// 32-bit word per cycle into a 15-row key memory, then reads the first key row
// (ST_KEYWAIT) and runs every round through the shared round unit, one round per
// cycle unless the last round waits on a stalled response still held in the
// output register. The block stalls its request side while a block is in flight;
// the result waits in an output register so the next block can be taken
// meanwhile. Key size code three acts as a 256-bit key. Configuration writes are
// always ready.
`timescale 1ns / 1ps
`include "aes_block_cipher_defines.svh"
module aes_block_cipher (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_kind,
   input  logic [63:0]   req_block_hi,
   input  logic [63:0]   req_block_lo,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [63:0]   rsp_result_hi,
   output logic [63:0]   rsp_result_lo,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [63:0]   csr_data
);
   import aes_pkg::*;

   aes_state_type state_ff, state_in;
   logic          kind_ff, kind_in;
   logic [127:0]  st_ff, st_in;
   logic [31:0]   win_ff [8];
   logic [31:0]   win_in [8];
   logic [95:0]   row_ff, row_in;
   logic [5:0]    word_ff, word_in;
   logic [2:0]    mod_ff, mod_in;
   logic [7:0]    rcon_ff, rcon_in;
   logic [3:0]    step_ff, step_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [127:0]  res_ff, res_in;
   logic [1:0]    key_size_ff;
   logic [63:0]   key_ff [4];

   logic [127:0]  rk_mem [KEY_ROWS];
   logic [127:0]  rk_q_ff;
   logic [3:0]    rk_addr;
   logic          mem_we;
   logic [3:0]    mem_waddr;
   logic [127:0]  mem_wdata;

   logic [3:0]    nk;
   logic [3:0]    nr;
   logic [5:0]    total_words;
   logic [63:0]   key_pair;
   logic [31:0]   key_word;
   logic [31:0]   prev;
   logic [31:0]   temp;
   logic [31:0]   new_word;
   logic          gen_rot;
   logic          last_step;
   logic          advance;
   logic [3:0]    next_step;
   round_ctrl_type rctrl;
   logic [127:0]  rnd_out;

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result_hi = res_ff[127:64];
   assign rsp_result_lo = res_ff[63:0];
   assign csr_ready     = 1'b1;

   always_comb begin
      case (key_size_ff)
         KEY_SIZE_128: nk = 4'd4;
         KEY_SIZE_192: nk = 4'd6;
         default:      nk = 4'd8;
      endcase
   end

   assign nr          = nk + 4'd6;
   assign total_words = {nr + 4'd1, 2'b00};
   assign key_pair    = key_ff[word_ff[2:1]];
   assign key_word    = word_ff[0] ? key_pair[31:0] : key_pair[63:32];
   assign prev        = win_ff[7];
   assign gen_rot     = (mod_ff == 3'd0);
   assign last_step   = (step_ff == nr);
   assign advance     = !last_step || !rsp_valid_ff || !rsp_stall;
   assign next_step   = step_ff + 4'd1;

   always_comb begin
      if (gen_rot) begin
         temp = sub_word({prev[23:0], prev[31:24]}) ^ {rcon_ff, 24'h0};
      end else if (nk == 4'd8 && mod_ff == 3'd4) begin
         temp = sub_word(prev);
      end else begin
         temp = prev;
      end
      if (word_ff < {2'b00, nk}) begin
         new_word = key_word;
      end else begin
         new_word = win_ff[3'(4'd8 - nk)] ^ temp;
      end
   end

   assign rctrl.decrypt = kind_ff;
   assign rctrl.first   = (step_ff == 4'd0);
   assign rctrl.last    = last_step;

   aes_round u_round (
      .state_in  (st_ff),
      .round_key (rk_q_ff),
      .ctrl      (rctrl),
      .state_out (rnd_out)
   );

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      st_in        = st_ff;
      win_in       = win_ff;
      row_in       = row_ff;
      word_in      = word_ff;
      mod_in       = mod_ff;
      rcon_in      = rcon_ff;
      step_in      = step_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_waddr    = word_ff[5:2];
      mem_wdata    = {row_ff, new_word};
      rk_addr      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               st_in    = {req_block_hi, req_block_lo};
               word_in  = '0;
               mod_in   = '0;
               rcon_in  = 8'h01;
               state_in = ST_EXPAND;
            end
         end
         ST_EXPAND: begin
            for (int j = 0; j < 7; j++) begin
               win_in[j] = win_ff[j + 1];
            end
            win_in[7] = new_word;
            row_in    = {row_ff[63:0], new_word};
            mem_we    = (word_ff[1:0] == 2'd3);
            mod_in    = (mod_ff == 3'(nk - 4'd1)) ? 3'd0 : mod_ff + 3'd1;
            if (gen_rot && word_ff >= {2'b00, nk}) begin
               rcon_in = xtime(rcon_ff);
            end
            if (word_ff == total_words - 6'd1) begin
               state_in = ST_KEYWAIT;
            end else begin
               word_in = word_ff + 6'd1;
            end
         end
         ST_KEYWAIT: begin
            rk_addr  = kind_ff ? nr : 4'd0;
            step_in  = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            // hold the row in flight until the step actually advances
            if (advance && !last_step) begin
               rk_addr = kind_ff ? (nr - next_step) : next_step;
            end else begin
               rk_addr = kind_ff ? (nr - step_ff) : step_ff;
            end
            if (advance) begin
               st_in   = rnd_out;
               step_in = next_step;
               if (last_step) begin
                  res_in       = rnd_out;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      st_ff   <= st_in;
      win_ff  <= win_in;
      row_ff  <= row_in;
      word_ff <= word_in;
      mod_ff  <= mod_in;
      rcon_ff <= rcon_in;
      step_ff <= step_in;
      res_ff  <= res_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rk_mem[mem_waddr] <= mem_wdata;
      end
      rk_q_ff <= rk_mem[rk_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_ff <= '0;
         for (int j = 0; j < 4; j++) begin
            key_ff[j] <= '0;
         end
      end else if (csr_valid) begin
         case (csr_index)
            CSR_KEY_SIZE:   key_size_ff <= csr_data[1:0];
            CSR_KEY_WORD_0: key_ff[0]   <= csr_data;
            CSR_KEY_WORD_1: key_ff[1]   <= csr_data;
            CSR_KEY_WORD_2: key_ff[2]   <= csr_data;
            CSR_KEY_WORD_3: key_ff[3]   <= csr_data;
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   `AES_ASSERT_IMPL(busy_stalls_a, state_ff != ST_IDLE, req_stall, "request taken while busy")
   `AES_ASSERT_NEXT(accept_expands_a, req_valid && !req_stall, state_ff == ST_EXPAND, "no expand")
   `AES_ASSERT_IMPL(step_bound_a, state_ff == ST_ROUND, step_ff <= nr, "round step overran")

endmodule
